>>> rtl/gbfad_pkg.sv
// shared types and constants of the gb2312 font address decoder
`timescale 1ns / 1ps
package gbfad_pkg;

   // glyph widths in display columns
   localparam int WIDE_GLYPH_WIDTH   = 16;
   localparam int NARROW_GLYPH_WIDTH = 8;

   localparam logic [7:0] WIDE_STEP   = 8'(WIDE_GLYPH_WIDTH);
   localparam logic [7:0] NARROW_STEP = 8'(NARROW_GLYPH_WIDTH);

   // byte codes
   localparam logic [7:0] LEAD_HI_FIRST = 8'hB0;
   localparam logic [7:0] LEAD_HI_LAST  = 8'hF7;
   localparam logic [7:0] LEAD_LO_FIRST = 8'hA1;
   localparam logic [7:0] LEAD_LO_LAST  = 8'hA3;
   localparam logic [7:0] TRAIL_FIRST   = 8'hA1;
   localparam logic [7:0] ASCII_FIRST   = 8'h20;
   localparam logic [7:0] ASCII_LAST    = 8'h7E;
   localparam logic [7:0] NUL_BYTE      = 8'h00;

   // font rom layout
   localparam int          ROW_SIZE     = 94;
   localparam int          HI_BASE      = 846;
   localparam int          WIDE_BYTES   = 32;
   localparam int          NARROW_BYTES = 16;
   localparam logic [17:0] NARROW_BASE  = 18'h3CF80;

   // glyph kind codes
   localparam logic KIND_WIDE   = 1'b0;
   localparam logic KIND_NARROW = 1'b1;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       last_byte;
      logic [7:0] start_column;
      logic [7:0] page_number;
      logic       reverse_video;
   } request_type;

   typedef struct packed {
      logic        glyph_valid;
      logic        glyph_kind;
      logic [17:0] font_address;
      logic [7:0]  glyph_column;
      logic [7:0]  glyph_page;
      logic        glyph_reverse;
      logic        string_done;
      logic [7:0]  end_column;
   } result_type;

endpackage

>>> rtl/gbfad_decode.sv
// string state and byte decode of the gb2312 font address decoder
`timescale 1ns / 1ps
module gbfad_decode
   import gbfad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_fire,
   input  request_type req_item,
   output logic        res_produce,
   output result_type  res_item
);

   logic       lead_pending_ff, lead_pending_in;
   logic [7:0] lead_byte_ff, lead_byte_in;
   logic [7:0] next_column_ff, next_column_in;
   logic [7:0] drawn_column_ff, drawn_column_in;
   logic       in_string_ff, in_string_in;
   logic [7:0] held_page_ff, held_page_in;
   logic       held_reverse_ff, held_reverse_in;

   logic        starting, pend, last, wide, narrow, lead_new, glyph, lead_hi;
   logic [7:0]  b, col_base, drawn_base, col_next, lead_off, trail_off, ascii_off;
   logic [7:0]  page_eff;
   logic        reverse_eff;
   logic [12:0] wide_index;
   logic [17:0] wide_addr, narrow_addr;

   always_comb begin
      b           = req_item.text_byte;
      starting    = !in_string_ff;
      col_base    = starting ? req_item.start_column : next_column_ff;
      drawn_base  = starting ? 8'd0 : drawn_column_ff;
      page_eff    = starting ? req_item.page_number : held_page_ff;
      reverse_eff = starting ? req_item.reverse_video : held_reverse_ff;
      pend        = starting ? 1'b0 : lead_pending_ff;
      last        = req_item.last_byte || (b == NUL_BYTE);

      wide     = pend && (b >= TRAIL_FIRST);
      lead_new = !wide && (b != NUL_BYTE) && !last &&
                 (b inside {[LEAD_HI_FIRST:LEAD_HI_LAST], [LEAD_LO_FIRST:LEAD_LO_LAST]});
      narrow   = !wide && !lead_new && (b inside {[ASCII_FIRST:ASCII_LAST]});
      glyph    = wide || narrow;

      // double-byte address from the held lead byte and this trail byte
      lead_hi    = lead_byte_ff >= LEAD_HI_FIRST;
      lead_off   = lead_hi ? (lead_byte_ff - LEAD_HI_FIRST) : (lead_byte_ff - LEAD_LO_FIRST);
      trail_off  = b - TRAIL_FIRST;
      wide_index = 13'(lead_off[6:0]) * 13'(ROW_SIZE) + 13'(trail_off[6:0])
                 + (lead_hi ? 13'(HI_BASE) : 13'd0);
      wide_addr  = 18'(wide_index) * 18'(WIDE_BYTES);

      ascii_off   = b - ASCII_FIRST;
      narrow_addr = 18'(ascii_off[6:0]) * 18'(NARROW_BYTES) + NARROW_BASE;

      col_next = col_base + (narrow ? NARROW_STEP : WIDE_STEP);

      lead_pending_in = lead_new;
      lead_byte_in    = lead_new ? b : lead_byte_ff;
      next_column_in  = glyph ? col_next : col_base;
      drawn_column_in = glyph ? col_next : drawn_base;
      in_string_in    = !last;
      held_page_in    = page_eff;
      held_reverse_in = reverse_eff;

      res_produce           = glyph || last;
      res_item.glyph_valid  = glyph;
      res_item.glyph_kind   = narrow ? KIND_NARROW : KIND_WIDE;
      res_item.font_address = narrow ? narrow_addr : (wide ? wide_addr : 18'd0);
      res_item.glyph_column = glyph ? col_base : 8'd0;
      res_item.glyph_page   = glyph ? page_eff : 8'd0;
      res_item.glyph_reverse = glyph && reverse_eff;
      res_item.string_done  = last;
      res_item.end_column   = last ? drawn_column_in : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_pending_ff <= 1'b0;
         lead_byte_ff    <= 8'd0;
         next_column_ff  <= 8'd0;
         drawn_column_ff <= 8'd0;
         in_string_ff    <= 1'b0;
         held_page_ff    <= 8'd0;
         held_reverse_ff <= 1'b0;
      end else if (req_fire) begin
         lead_pending_ff <= lead_pending_in;
         lead_byte_ff    <= lead_byte_in;
         next_column_ff  <= next_column_in;
         drawn_column_ff <= drawn_column_in;
         in_string_ff    <= in_string_in;
         held_page_ff    <= held_page_in;
         held_reverse_ff <= held_reverse_in;
      end
   end

   // a lead byte only waits inside a string
   a_pending_in_string: assert property (@(posedge clock) disable iff (reset)
      lead_pending_ff |-> in_string_ff)
      else $error("lead byte pending outside a string");

   // the final byte closes the string
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      req_fire && last |=> !in_string_ff && !lead_pending_ff)
      else $error("string still open after its final byte");

   // a done transaction always comes with a result
   a_done_produces: assert property (@(posedge clock) disable iff (reset)
      req_fire && last |-> res_produce && res_item.string_done)
      else $error("final byte gave no done result");

endmodule

>>> rtl/gbfad_skid.sv
// output register with skid stage for the result channel
`timescale 1ns / 1ps
module gbfad_skid
   import gbfad_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_item,
   output logic       push_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_item
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_item_ff, out_item_in;
   result_type skid_item_ff, skid_item_in;
   logic       out_free;

   always_comb begin
      out_free      = !out_valid_ff || out_ready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_item_in   = out_item_ff;
      skid_item_in  = skid_item_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_item_in   = skid_item_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_item_in  = push_item;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_item_in  = push_item;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

   assign push_ready = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_item   = out_item_ff;

   // the skid stage only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds data with empty output register");

   // a push into a stalled output lands in the skid stage
   a_push_stalled: assert property (@(posedge clock) disable iff (reset)
      push && out_valid_ff && !out_ready |=> skid_valid_ff)
      else $error("result lost on stalled output");

   // a drained output is refilled from the skid stage
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> out_valid_ff && !skid_valid_ff)
      else $error("skid stage not moved to output");

endmodule

>>> rtl/gb2312_font_address_decoder_top.sv
// top level of the gb2312 font address decoder
`timescale 1ns / 1ps
// usage
// - req channel carries one text byte per transaction; tlast marks the final
//   byte of a string, a zero byte also ends the string
// - start column, page and reverse flag are taken from the first transaction
//   of a string and ignored on later ones
// - rsp channel carries one transaction per placed glyph and one on the final
//   byte; a lead byte waiting for its trail byte and skipped bytes give none
// - a double-byte glyph is reported on its trail byte transaction
// - the result of a taken req transaction is registered in the output register
// - throughput: one byte per cycle while req_tready is high, set by the single
//   decode pass between the string state registers and the output register
// - when rsp stalls, one more result is caught in the skid stage and
//   req_tready drops until it drains; no transaction is dropped
// - reset (synchronous, active high) clears the string state and empties
//   the output register and skid stage
// - columns wrap modulo 256
module gb2312_font_address_decoder_top
   import gbfad_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input byte channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // text_byte, start_column, page_number
   input  logic        req_tlast,   // last_byte
   input  logic [0:0]  req_tuser,   // reverse_video
   // glyph result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // font_address, glyph_column, glyph_page,
                                    // end_column, zero fill
   output logic        rsp_tlast,   // string_done
   output logic [2:0]  rsp_tuser    // glyph_valid, glyph_kind, glyph_reverse
);

   request_type req_item;
   result_type  dec_item, out_item;
   logic        req_fire, dec_produce, push_ready;

   // unpack the request transaction
   assign req_item.text_byte     = req_tdata[7:0];
   assign req_item.start_column  = req_tdata[15:8];
   assign req_item.page_number   = req_tdata[23:16];
   assign req_item.last_byte     = req_tlast;
   assign req_item.reverse_video = req_tuser[0];

   assign req_tready = push_ready;
   assign req_fire   = req_tvalid && push_ready;

   // byte decode and string state
   gbfad_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_item    (req_item),
      .res_produce (dec_produce),
      .res_item    (dec_item)
   );

   // result register and skid stage
   gbfad_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (req_fire && dec_produce),
      .push_item  (dec_item),
      .push_ready (push_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item)
   );

   // pack the result transaction
   assign rsp_tdata = {6'd0, out_item.end_column, out_item.glyph_page,
                       out_item.glyph_column, out_item.font_address};
   assign rsp_tlast = out_item.string_done;
   assign rsp_tuser = {out_item.glyph_reverse, out_item.glyph_kind, out_item.glyph_valid};

endmodule
